### rtl/core/tsf_pkg.sv
// tsf_pkg: shared types and constants of the touch sample filter controller
// event codes, panel modes, report kinds and the result record
// no dependencies
`timescale 1ns / 1ps

package tsf_pkg;

   localparam int FIELD_BITS = 10;
   localparam int COUNT_BITS = 2;
   localparam logic [FIELD_BITS-1:0] ERROR_LIMIT_RESET = 10'd10;

   typedef enum logic [1:0] {
      OP_PEN_CHANGE = 2'd0,
      OP_CONV_DONE  = 2'd1,
      OP_TIMER_TICK = 2'd2,
      OP_UNUSED     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_WAIT_DOWN = 2'd0,
      MODE_MEASURE   = 2'd1,
      MODE_WAIT_UP   = 2'd2,
      MODE_UNCHANGED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REPORT_NONE    = 2'd0,
      REPORT_TOUCH   = 2'd1,
      REPORT_RELEASE = 2'd2
   } report_type;

   localparam logic [COUNT_BITS-1:0] LAST_SAMPLE = 2'd3;

   typedef struct packed {
      mode_type              mode;
      logic                  start;
      logic                  arm;
      report_type            kind;
      logic [FIELD_BITS-1:0] x_pos;
      logic [FIELD_BITS-1:0] y_pos;
   } rsp_type;

   // state update that goes with one event
   typedef struct packed {
      logic                  store_we;
      logic                  count_we;
      logic [COUNT_BITS-1:0] count;
   } upd_type;

endpackage

### rtl/core/tsf_axis.sv
// tsf_axis: batch check and four-sample mean for one axis
// depends on tsf_pkg
`timescale 1ns / 1ps

module tsf_axis #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic [SAMPLE_BITS-1:0]          s0,
   input  logic [SAMPLE_BITS-1:0]          s1,
   input  logic [SAMPLE_BITS-1:0]          s2,
   input  logic [SAMPLE_BITS-1:0]          s3,
   input  logic [tsf_pkg::FIELD_BITS-1:0]  error_limit,
   output logic                            ok,
   output logic [tsf_pkg::FIELD_BITS-1:0]  mean
);

   localparam int CW = (SAMPLE_BITS > tsf_pkg::FIELD_BITS) ? SAMPLE_BITS
                                                            : tsf_pkg::FIELD_BITS;

   logic [SAMPLE_BITS:0]   sum01;
   logic [SAMPLE_BITS:0]   sum12;
   logic [SAMPLE_BITS-1:0] avg01;
   logic [SAMPLE_BITS-1:0] avg12;
   logic [SAMPLE_BITS-1:0] dev2;
   logic [SAMPLE_BITS-1:0] dev3;
   logic [SAMPLE_BITS+1:0] sum4;
   logic [CW-1:0]          limit_ext;

   always_comb begin
      sum01 = {1'b0, s0} + {1'b0, s1};
      sum12 = {1'b0, s1} + {1'b0, s2};
      avg01 = sum01[SAMPLE_BITS:1];
      avg12 = sum12[SAMPLE_BITS:1];
      dev2  = (avg01 > s2) ? (avg01 - s2) : (s2 - avg01);
      dev3  = (avg12 > s3) ? (avg12 - s3) : (s3 - avg12);
      limit_ext = CW'(error_limit);
      ok = (CW'(dev2) <= limit_ext) && (CW'(dev3) <= limit_ext);
      sum4 = {2'b00, s0} + {2'b00, s1} + {2'b00, s2} + {2'b00, s3};
      mean = tsf_pkg::FIELD_BITS'(sum4[SAMPLE_BITS+1:2]);
   end

endmodule

### rtl/core/tsf_event.sv
// tsf_event: event decode, result fields and sample counter update
// depends on tsf_pkg
`timescale 1ns / 1ps

module tsf_event (
   input  tsf_pkg::opcode_type                 opcode,
   input  logic                                down,
   input  logic [tsf_pkg::COUNT_BITS-1:0]      count,
   input  logic                                batch_ok,
   input  logic [tsf_pkg::FIELD_BITS-1:0]      x_mean,
   input  logic [tsf_pkg::FIELD_BITS-1:0]      y_mean,
   output tsf_pkg::rsp_type                    rsp,
   output tsf_pkg::upd_type                    upd
);

   always_comb begin
      rsp.mode   = tsf_pkg::MODE_UNCHANGED;
      rsp.start  = 1'b0;
      rsp.arm    = 1'b0;
      rsp.kind   = tsf_pkg::REPORT_NONE;
      rsp.x_pos  = '0;
      rsp.y_pos  = '0;
      upd.store_we = 1'b0;
      upd.count_we = 1'b0;
      upd.count    = '0;
      case (opcode)
         tsf_pkg::OP_PEN_CHANGE: begin
            if (down) begin
               rsp.mode  = tsf_pkg::MODE_MEASURE;
               rsp.start = 1'b1;
            end else begin
               rsp.mode = tsf_pkg::MODE_WAIT_DOWN;
            end
         end
         tsf_pkg::OP_CONV_DONE: begin
            upd.count_we = 1'b1;
            if (!down) begin
               rsp.kind = tsf_pkg::REPORT_RELEASE;
               rsp.mode = tsf_pkg::MODE_WAIT_DOWN;
            end else if (count == tsf_pkg::LAST_SAMPLE) begin
               rsp.mode = tsf_pkg::MODE_WAIT_UP;
               rsp.arm  = 1'b1;
               if (batch_ok) begin
                  rsp.kind  = tsf_pkg::REPORT_TOUCH;
                  rsp.x_pos = x_mean;
                  rsp.y_pos = y_mean;
               end
            end else begin
               upd.store_we = 1'b1;
               upd.count    = count + 1'b1;
               rsp.mode     = tsf_pkg::MODE_MEASURE;
               rsp.start    = 1'b1;
            end
         end
         tsf_pkg::OP_TIMER_TICK: begin
            if (down) begin
               rsp.mode  = tsf_pkg::MODE_MEASURE;
               rsp.start = 1'b1;
            end else begin
               rsp.kind = tsf_pkg::REPORT_RELEASE;
               rsp.mode = tsf_pkg::MODE_WAIT_DOWN;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/core/touch_sample_filter_controller_unit.sv
// touch_sample_filter_controller_unit: top level of the touch sample filter
// depends on tsf_pkg, tsf_axis, tsf_event
//
// usage:
//   req_* carries one event per request: opcode (pen change, conversion
//   done, timer tick), the X/Y samples and the two pen-up flags.
//   rsp_* returns exactly one result per request: next panel mode,
//   start-conversion, arm-timer, report kind and the four-sample means.
//   csr_* writes the error limit; csr_ready is always high. write it only
//   while no request is in flight.
// timing:
//   a request is taken into the input register, and its result, computed
//   from that register and the sample store in one pass, lands in the
//   result register once that register is free or being emptied. one
//   request per cycle is sustained while rsp_ready stays high; the limit
//   is the single compare/add pass between the two registers.
// stalls:
//   while rsp_ready is low the result register holds and the input
//   register can still take one more request; req_ready then drops.
// reset:
//   both registers empty, sample counter zero, error limit 10. the sample
//   store is not cleared; every entry is written before it is used.
`timescale 1ns / 1ps

module touch_sample_filter_controller_unit #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [tsf_pkg::FIELD_BITS-1:0]     req_x_sample,
   input  logic [tsf_pkg::FIELD_BITS-1:0]     req_y_sample,
   input  logic                               req_x_up_flag,
   input  logic                               req_y_up_flag,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_panel_mode,
   output logic                               rsp_start_conversion,
   output logic                               rsp_arm_timer,
   output logic [1:0]                         rsp_report_kind,
   output logic [tsf_pkg::FIELD_BITS-1:0]     rsp_x_position,
   output logic [tsf_pkg::FIELD_BITS-1:0]     rsp_y_position,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tsf_pkg::FIELD_BITS-1:0]     csr_wdata
);

   localparam int DEPTH = 1 << tsf_pkg::COUNT_BITS;

   // input register
   logic                          in_valid_ff;
   tsf_pkg::opcode_type           in_op_ff;
   logic [SAMPLE_BITS-1:0]        in_x_ff;
   logic [SAMPLE_BITS-1:0]        in_y_ff;
   logic                          in_down_ff;

   // result register
   logic                          out_valid_ff;
   tsf_pkg::rsp_type              out_ff;

   logic [tsf_pkg::FIELD_BITS-1:0] limit_ff;
   logic [tsf_pkg::COUNT_BITS-1:0] count_ff;
   logic [SAMPLE_BITS-1:0]         x_store_ff [DEPTH];
   logic [SAMPLE_BITS-1:0]         y_store_ff [DEPTH];

   logic                           advance;
   logic                           ok_x;
   logic                           ok_y;
   logic [tsf_pkg::FIELD_BITS-1:0] mean_x;
   logic [tsf_pkg::FIELD_BITS-1:0] mean_y;
   tsf_pkg::rsp_type               rsp_in;
   tsf_pkg::upd_type               upd;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // the fourth sample goes straight from the input register into the check
   tsf_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
      .s0(x_store_ff[0]), .s1(x_store_ff[1]), .s2(x_store_ff[2]), .s3(in_x_ff),
      .error_limit(limit_ff), .ok(ok_x), .mean(mean_x)
   );

   tsf_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
      .s0(y_store_ff[0]), .s1(y_store_ff[1]), .s2(y_store_ff[2]), .s3(in_y_ff),
      .error_limit(limit_ff), .ok(ok_y), .mean(mean_y)
   );

   tsf_event u_event (
      .opcode(in_op_ff), .down(in_down_ff), .count(count_ff),
      .batch_ok(ok_x && ok_y), .x_mean(mean_x), .y_mean(mean_y),
      .rsp(rsp_in), .upd(upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= tsf_pkg::ERROR_LIMIT_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance && upd.count_we) begin
            count_ff <= upd.count;
         end
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= tsf_pkg::opcode_type'(req_opcode);
         in_x_ff    <= SAMPLE_BITS'(req_x_sample);
         in_y_ff    <= SAMPLE_BITS'(req_y_sample);
         in_down_ff <= !req_x_up_flag && !req_y_up_flag;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
      if (advance && upd.store_we) begin
         x_store_ff[count_ff] <= in_x_ff;
         y_store_ff[count_ff] <= in_y_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_panel_mode       = out_ff.mode;
   assign rsp_start_conversion = out_ff.start;
   assign rsp_arm_timer        = out_ff.arm;
   assign rsp_report_kind      = out_ff.kind;
   assign rsp_x_position       = out_ff.x_pos;
   assign rsp_y_position       = out_ff.y_pos;

   // counter only moves on conversion events
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!advance || in_op_ff != tsf_pkg::OP_CONV_DONE) |=> $stable(count_ff))
      else $error("sample counter changed without a conversion");

   // a touch report always closes a batch
   a_touch_arms: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == tsf_pkg::REPORT_TOUCH)
         |-> (out_ff.arm && out_ff.mode == tsf_pkg::MODE_WAIT_UP))
      else $error("touch report without timer arm");

   a_start_measure: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.start) |-> (out_ff.mode == tsf_pkg::MODE_MEASURE))
      else $error("start conversion outside measure mode");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind != tsf_pkg::REPORT_TOUCH)
         |-> (out_ff.x_pos == '0 && out_ff.y_pos == '0))
      else $error("position set without touch report");

   // a stalled result must not be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> ($stable(out_ff) && out_valid_ff))
      else $error("stalled result changed");

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for touch_sample_filter_controller_unit
// scoreboard class predicts one result per request; tasks drive requests and the error limit
// depends on tsf_pkg and the controller rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT = 1000;
   localparam int FIELD_BITS = tsf_pkg::FIELD_BITS;
   localparam int COUNT_BITS = tsf_pkg::COUNT_BITS;

   class touch_filter_scoreboard;
      logic [FIELD_BITS-1:0] limit;
      logic [COUNT_BITS-1:0] count;
      int                    x_hist[4];
      int                    y_hist[4];
      tsf_pkg::rsp_type      expected_q[$];
      int                    errors;
      int                    reported;
      int                    checked;
      int                    touches;
      int                    rejects;
      int                    releases;

      function new();
         limit    = tsf_pkg::ERROR_LIMIT_RESET;
         count    = '0;
         errors   = 0;
         reported = 0;
         checked  = 0;
         touches  = 0;
         rejects  = 0;
         releases = 0;
         for (int i = 0; i < 4; i++) begin
            x_hist[i] = 0;
            y_hist[i] = 0;
         end
      endfunction

      function void write_limit(logic [FIELD_BITS-1:0] value);
         limit = value;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function bit axis_passes(int s0, int s1, int s2, int s3);
         int avg01;
         int avg12;
         int dev;
         avg01 = (s0 + s1) >> 1;
         avg12 = (s1 + s2) >> 1;
         dev = (avg01 > s2) ? avg01 - s2 : s2 - avg01;
         if (dev > int'(limit)) return 1'b0;
         dev = (avg12 > s3) ? avg12 - s3 : s3 - avg12;
         if (dev > int'(limit)) return 1'b0;
         return 1'b1;
      endfunction

      function void note_request(logic [1:0] op, logic [FIELD_BITS-1:0] xs,
                                 logic [FIELD_BITS-1:0] ys, logic xu, logic yu);
         tsf_pkg::rsp_type e;
         bit               down;
         int               idx;
         e       = '0;
         e.mode  = tsf_pkg::MODE_UNCHANGED;
         e.kind  = tsf_pkg::REPORT_NONE;
         down    = !xu && !yu;
         case (op)
            tsf_pkg::OP_PEN_CHANGE: begin
               if (down) begin
                  e.mode  = tsf_pkg::MODE_MEASURE;
                  e.start = 1'b1;
               end else begin
                  e.mode = tsf_pkg::MODE_WAIT_DOWN;
               end
            end
            tsf_pkg::OP_CONV_DONE: begin
               if (down) begin
                  idx = int'(count);
                  x_hist[idx] = int'(xs);
                  y_hist[idx] = int'(ys);
                  if (count == tsf_pkg::LAST_SAMPLE) begin
                     if (axis_passes(x_hist[0], x_hist[1], x_hist[2], x_hist[3]) &&
                         axis_passes(y_hist[0], y_hist[1], y_hist[2], y_hist[3])) begin
                        e.kind  = tsf_pkg::REPORT_TOUCH;
                        e.x_pos = FIELD_BITS'((x_hist[0] + x_hist[1] + x_hist[2]
                                               + x_hist[3]) >> 2);
                        e.y_pos = FIELD_BITS'((y_hist[0] + y_hist[1] + y_hist[2]
                                               + y_hist[3]) >> 2);
                        touches++;
                     end else begin
                        rejects++;
                     end
                     count  = '0;
                     e.mode = tsf_pkg::MODE_WAIT_UP;
                     e.arm  = 1'b1;
                  end else begin
                     count   = count + 1'b1;
                     e.mode  = tsf_pkg::MODE_MEASURE;
                     e.start = 1'b1;
                  end
               end else begin
                  count  = '0;
                  e.kind = tsf_pkg::REPORT_RELEASE;
                  e.mode = tsf_pkg::MODE_WAIT_DOWN;
                  releases++;
               end
            end
            tsf_pkg::OP_TIMER_TICK: begin
               if (down) begin
                  e.mode  = tsf_pkg::MODE_MEASURE;
                  e.start = 1'b1;
               end else begin
                  e.kind = tsf_pkg::REPORT_RELEASE;
                  e.mode = tsf_pkg::MODE_WAIT_DOWN;
                  releases++;
               end
            end
            default: begin
               // unused opcode leaves state alone
            end
         endcase
         expected_q.push_back(e);
      endfunction

      function void check_result(tsf_pkg::rsp_type got);
         tsf_pkg::rsp_type e;
         bit               bad;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result: mode=%0d start=%0d arm=%0d kind=%0d x=%0d y=%0d",
                        got.mode, got.start, got.arm, got.kind, got.x_pos, got.y_pos);
            end
            return;
         end
         e = expected_q.pop_front();
         checked++;
         bad = (got.mode !== e.mode) || (got.start !== e.start) || (got.arm !== e.arm) ||
               (got.kind !== e.kind) || (got.x_pos !== e.x_pos) || (got.y_pos !== e.y_pos);
         if (bad) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("result %0d mismatch: expected mode=%0d start=%0d arm=%0d",
                        checked, e.mode, e.start, e.arm);
               $display("   expected kind=%0d x=%0d y=%0d", e.kind, e.x_pos, e.y_pos);
               $display("   actual   mode=%0d start=%0d arm=%0d kind=%0d x=%0d y=%0d",
                        got.mode, got.start, got.arm, got.kind, got.x_pos, got.y_pos);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_opcode;
   logic [FIELD_BITS-1:0] req_x_sample;
   logic [FIELD_BITS-1:0] req_y_sample;
   logic                  req_x_up_flag;
   logic                  req_y_up_flag;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_panel_mode;
   logic                  rsp_start_conversion;
   logic                  rsp_arm_timer;
   logic [1:0]            rsp_report_kind;
   logic [FIELD_BITS-1:0] rsp_x_position;
   logic [FIELD_BITS-1:0] rsp_y_position;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [FIELD_BITS-1:0] csr_wdata;

   touch_filter_scoreboard sb = new();

   int items_sent   = 0;
   int send_burst   = 0;
   int recv_burst   = 0;
   int cur_limit    = 10;
   int limit_writes = 0;
   int idle_cycles  = 0;

   touch_sample_filter_controller_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_x_sample         (req_x_sample),
      .req_y_sample         (req_y_sample),
      .req_x_up_flag        (req_x_up_flag),
      .req_y_up_flag        (req_y_up_flag),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_panel_mode       (rsp_panel_mode),
      .rsp_start_conversion (rsp_start_conversion),
      .rsp_arm_timer        (rsp_arm_timer),
      .rsp_report_kind      (rsp_report_kind),
      .rsp_x_position       (rsp_x_position),
      .rsp_y_position       (rsp_y_position),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // observe both channels and the register port at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_limit(csr_wdata);
         if (req_valid && req_ready)
            sb.note_request(req_opcode, req_x_sample, req_y_sample,
                            req_x_up_flag, req_y_up_flag);
         if (rsp_valid && rsp_ready)
            sb.check_result(tsf_pkg::rsp_type'({rsp_panel_mode, rsp_start_conversion,
                                                rsp_arm_timer, rsp_report_kind,
                                                rsp_x_position, rsp_y_position}));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stall per result, with bursts of no stalls
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (recv_burst > 0) begin
            stall = 0;
            recv_burst--;
         end else begin
            stall = $urandom_range(0, 14);
            if ($urandom_range(0, 39) == 0) recv_burst = $urandom_range(20, 60);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic drive_event(input logic [1:0] op, input logic [FIELD_BITS-1:0] xv,
                              input logic [FIELD_BITS-1:0] yv, input logic xu, input logic yu);
      int gap;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_x_sample  <= xv;
      req_y_sample  <= yv;
      req_x_up_flag <= xu;
      req_y_up_flag <= yu;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op != tsf_pkg::OP_UNUSED) items_sent++;
   endtask

   task automatic send_batch(input int xv[4], input int yv[4]);
      for (int i = 0; i < 4; i++)
         drive_event(tsf_pkg::OP_CONV_DONE, FIELD_BITS'(xv[i]), FIELD_BITS'(yv[i]),
                     1'b0, 1'b0);
   endtask

   // hold off new requests until every result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_error_limit(input int value);
      csr_valid <= 1'b1;
      csr_wdata <= FIELD_BITS'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_limit = value;
      limit_writes++;
      @(posedge clock);
   endtask

   // spread around the limit so batches land on both sides of the filter
   function automatic int pick_spread();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return cur_limit / 2;
         2:       return cur_limit;
         default: return cur_limit * 2 + 5;
      endcase
   endfunction

   function automatic int jitter_sample(int base, int spread);
      int v;
      v = base + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v;
   endfunction

   task automatic pen_up_event();
      int       sel;
      int       which;
      logic [1:0] flags;
      which = $urandom_range(1, 3);
      flags = which[1:0];
      sel   = $urandom_range(0, 2);
      if (sel == 0)
         drive_event(tsf_pkg::OP_PEN_CHANGE, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     flags[0], flags[1]);
      else if (sel == 1)
         drive_event(tsf_pkg::OP_CONV_DONE, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     flags[0], flags[1]);
      else
         drive_event(tsf_pkg::OP_TIMER_TICK, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     flags[0], flags[1]);
   endtask

   task automatic touch_session();
      int batches;
      int bx;
      int by;
      int sx;
      int sy;
      drive_event(tsf_pkg::OP_PEN_CHANGE, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                  1'b0, 1'b0);
      batches = $urandom_range(1, 3);
      for (int b = 0; b < batches; b++) begin
         if ($urandom_range(0, 3) == 0)
            drive_event(tsf_pkg::OP_TIMER_TICK, FIELD_BITS'($urandom),
                        FIELD_BITS'($urandom), 1'b0, 1'b0);
         bx = $urandom_range(0, 1023);
         by = $urandom_range(0, 1023);
         sx = pick_spread();
         sy = pick_spread();
         for (int k = 0; k < 4; k++)
            drive_event(tsf_pkg::OP_CONV_DONE, FIELD_BITS'(jitter_sample(bx, sx)),
                        FIELD_BITS'(jitter_sample(by, sy)), 1'b0, 1'b0);
         // repeat timer fires while the pen is held
         drive_event(tsf_pkg::OP_TIMER_TICK, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     1'b0, 1'b0);
      end
      pen_up_event();
   endtask

   // batch cut short; a pen-up tick leaves the sample count where it was
   task automatic broken_session();
      int n;
      drive_event(tsf_pkg::OP_PEN_CHANGE, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                  1'b0, 1'b0);
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++)
         drive_event(tsf_pkg::OP_CONV_DONE, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     1'b0, 1'b0);
      pen_up_event();
   endtask

   task automatic noise_events();
      int n;
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++)
         drive_event(2'($urandom_range(0, 3)), FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_random(input int n);
      int target;
      int pick;
      target = items_sent + n;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) touch_session();
         else if (pick <= 8) broken_session();
         else noise_events();
      end
   endtask

   initial begin
      req_valid     <= 1'b0;
      req_opcode    <= tsf_pkg::OP_PEN_CHANGE;
      req_x_sample  <= '0;
      req_y_sample  <= '0;
      req_x_up_flag <= 1'b0;
      req_y_up_flag <= 1'b0;
      csr_valid     <= 1'b0;
      csr_wdata     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the reset limit of 10
      drive_event(tsf_pkg::OP_UNUSED, 10'h3ff, 10'h3ff, 1'b1, 1'b1);
      drive_event(tsf_pkg::OP_PEN_CHANGE, 10'h000, 10'h000, 1'b1, 1'b0);
      drive_event(tsf_pkg::OP_PEN_CHANGE, 10'h000, 10'h000, 1'b0, 1'b1);
      drive_event(tsf_pkg::OP_PEN_CHANGE, 10'h3ff, 10'h000, 1'b0, 1'b0);
      drive_event(tsf_pkg::OP_TIMER_TICK, 10'h000, 10'h3ff, 1'b0, 1'b0);
      drive_event(tsf_pkg::OP_TIMER_TICK, 10'h3ff, 10'h3ff, 1'b1, 1'b1);
      // full-scale corners pass
      send_batch('{1023, 1023, 1023, 1023}, '{0, 0, 0, 0});
      // first compare off by one past the limit
      send_batch('{0, 0, 11, 11}, '{500, 500, 500, 500});
      // both compares exactly at the limit, odd sums truncate
      send_batch('{0, 0, 10, 15}, '{1, 2, 1, 11});
      // second compare fails on y only
      send_batch('{100, 100, 100, 100}, '{100, 100, 100, 111});
      // pen up in the middle of a batch clears the count
      drive_event(tsf_pkg::OP_CONV_DONE, 10'd200, 10'd200, 1'b0, 1'b0);
      drive_event(tsf_pkg::OP_CONV_DONE, 10'd200, 10'd200, 1'b1, 1'b0);
      // tick mid-batch keeps the count
      drive_event(tsf_pkg::OP_CONV_DONE, 10'd300, 10'd300, 1'b0, 1'b0);
      drive_event(tsf_pkg::OP_TIMER_TICK, 10'd0, 10'd0, 1'b0, 1'b1);
      send_batch('{301, 302, 303, 304}, '{299, 298, 297, 296});
      wait_for_results();

      write_error_limit(0);
      send_batch('{512, 512, 512, 512}, '{7, 7, 7, 7});
      send_batch('{512, 512, 512, 513}, '{7, 7, 7, 7});
      wait_for_results();

      write_error_limit(1023);
      send_batch('{0, 1023, 0, 1023}, '{1023, 0, 1023, 0});
      wait_for_results();

      // random phases across several limits
      write_error_limit(0);
      run_random(200);
      wait_for_results();
      write_error_limit(1023);
      run_random(100);
      wait_for_results();
      run_random(100);
      wait_for_results();
      write_error_limit(5);
      run_random(200);
      wait_for_results();
      write_error_limit($urandom_range(0, 1023));
      run_random(200);
      wait_for_results();
      write_error_limit($urandom_range(1, 40));
      run_random(200);
      wait_for_results();
      write_error_limit(10);
      run_random(200);
      wait_for_results();
      repeat (8) @(posedge clock);

      if (sb.outstanding() != 0) begin
         $display("%0d expected results never arrived", sb.outstanding());
         sb.errors += sb.outstanding();
      end
      $display("covered %0d requests, %0d results checked over %0d error limit writes",
               items_sent, sb.checked, limit_writes);
      $display("filter outcomes: %0d touches, %0d rejected batches, %0d releases",
               sb.touches, sb.rejects, sb.releases);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tsf_pkg.sv
rtl/core/tsf_axis.sv
rtl/core/tsf_event.sv
rtl/core/touch_sample_filter_controller_unit.sv
bench/tb_top.sv
